### hdl/toroidal_box_blur_passes_assert.svh
// Assertion macros for the box blur block.
// The clock and reset names clk and arst_n must exist where these are used.
`ifndef TOROIDAL_BOX_BLUR_PASSES_ASSERT_SVH
`define TOROIDAL_BOX_BLUR_PASSES_ASSERT_SVH

// Consequent in the same cycle as the antecedent.
`define TBB_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Consequent in the cycle after the antecedent.
`define TBB_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### hdl/tbb_pkg.sv
// ----------------------------------------------------------------------------
// tbb_pkg
// Shared constants and types of the toroidal box blur block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tbb_pkg;

	localparam int SIDE_LOG2 = 9;
	localparam int ADDR_W = 2 * SIDE_LOG2;
	localparam int FRAME_DEPTH = 1 << ADDR_W;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_READ = 2'd1;
	localparam logic [1:0] OP_RUN = 2'd2;

	localparam logic [3:0] PASS_COUNT_RESET = 4'd6;

	typedef struct packed {
		logic [1:0] opcode;
		logic buffer_select;
		logic [8:0] x_coord;
		logic [8:0] y_coord;
		logic [7:0] write_value;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} q_head_t;

endpackage

### hdl/tbb_if.sv
// ----------------------------------------------------------------------------
// tbb_if
// Request and response channels of the box blur block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tbb_req_if;
	logic valid;
	logic ready;
	logic [1:0] opcode;
	logic buffer_select;
	logic [8:0] x_coord;
	logic [8:0] y_coord;
	logic [7:0] write_value;

	modport source (output valid, opcode, buffer_select, x_coord, y_coord, write_value,
		input ready);
	modport sink (input valid, opcode, buffer_select, x_coord, y_coord, write_value,
		output ready);
endinterface

interface tbb_rsp_if;
	logic valid;
	logic ready;
	logic [7:0] read_value;

	modport source (output valid, read_value, input ready);
	modport sink (input valid, read_value, output ready);
endinterface

### hdl/tbb_ram.sv
// ----------------------------------------------------------------------------
// tbb_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tbb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### hdl/tbb_front.sv
// ----------------------------------------------------------------------------
// tbb_front
// Request intake: a two-entry queue in front of the execution unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tbb_front import tbb_pkg::*; (
	input logic clk,
	input logic arst_n,
	tbb_req_if.sink req,
	output q_head_t head,
	input logic pop
);

	cmd_t ent_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] cnt_q;
	logic push;
	logic take;

	assign req.ready = (cnt_q != 2'd2);
	assign push = req.valid && req.ready;
	assign take = pop && (cnt_q != 2'd0);

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= '{opcode: req.opcode, buffer_select: req.buffer_select,
				x_coord: req.x_coord, y_coord: req.y_coord, write_value: req.write_value};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (take) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, take};
		end
	end

	assign head.valid = (cnt_q != 2'd0);
	assign head.cmd = ent_q[rd_ptr_q];

endmodule

### hdl/tbb_back.sv
// ----------------------------------------------------------------------------
// tbb_back
// Execution unit: frame memories, read and write service, blur sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tbb_back import tbb_pkg::*; (
	input logic clk,
	input logic arst_n,
	input q_head_t head,
	output logic pop,
	input logic [3:0] pass_count,
	output logic rsp_valid,
	input logic rsp_ready,
	output logic [7:0] rsp_data
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_RUN = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	localparam logic [3:0] TAP_SUM = 4'd9;
	localparam logic [3:0] TAP_WRITE = 4'd10;
	localparam logic [12:0] DIV9_MUL = 13'd7282;

	logic [1:0] st_q;
	logic [3:0] pass_q;
	logic [3:0] npass_q;
	logic [ADDR_W-1:0] pix_q;
	logic [3:0] tap_q;
	logic [11:0] sum_q;
	logic sel_q;
	logic rsp_valid_q;
	logic [7:0] rsp_q;

	logic out_free;
	logic [ADDR_W-1:0] cmd_addr;
	logic [ADDR_W-1:0] tap_addr;
	logic [3:0] off;
	logic [SIDE_LOG2-1:0] tx;
	logic [SIDE_LOG2-1:0] ty;
	logic [7:0] rdata [2];
	logic [7:0] src_data;
	logic [24:0] prod;
	logic we [2];
	logic [ADDR_W-1:0] waddr;
	logic [7:0] wdata;
	logic [ADDR_W-1:0] raddr [2];

	function automatic logic [3:0] tap_off(input logic [3:0] t);
		logic [3:0] r;
		unique case (t)
			4'd0: r = {2'd0, 2'd0};
			4'd1: r = {2'd0, 2'd1};
			4'd2: r = {2'd0, 2'd2};
			4'd3: r = {2'd1, 2'd0};
			4'd4: r = {2'd1, 2'd1};
			4'd5: r = {2'd1, 2'd2};
			4'd6: r = {2'd2, 2'd0};
			4'd7: r = {2'd2, 2'd1};
			4'd8: r = {2'd2, 2'd2};
			default: r = {2'd1, 2'd1};
		endcase
		return r;
	endfunction

	function automatic logic [SIDE_LOG2-1:0] step(input logic [SIDE_LOG2-1:0] c,
		input logic [1:0] d);
		logic [SIDE_LOG2-1:0] r;
		case (d)
			2'd0: r = c - 1'b1;
			2'd2: r = c + 1'b1;
			default: r = c;
		endcase
		return r;
	endfunction

	assign out_free = !rsp_valid_q || rsp_ready;
	assign pop = (st_q == ST_IDLE) && head.valid && out_free;

	assign cmd_addr = {head.cmd.y_coord[SIDE_LOG2-1:0], head.cmd.x_coord[SIDE_LOG2-1:0]};
	assign off = tap_off(tap_q);
	assign tx = step(pix_q[SIDE_LOG2-1:0], off[1:0]);
	assign ty = step(pix_q[ADDR_W-1:SIDE_LOG2], off[3:2]);
	assign tap_addr = {ty, tx};
	assign src_data = rdata[pass_q[0]];
	assign prod = {1'b0, sum_q} * {12'd0, DIV9_MUL};

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			raddr[i] = ((st_q == ST_RUN) && (pass_q[0] == i[0])) ? tap_addr : cmd_addr;
			we[i] = 1'b0;
		end
		waddr = cmd_addr;
		wdata = head.cmd.write_value;
		if (st_q == ST_RUN) begin
			waddr = pix_q;
			wdata = prod[23:16];
			we[~pass_q[0]] = (tap_q == TAP_WRITE);
		end else if (pop && (head.cmd.opcode == OP_WRITE)) begin
			we[head.cmd.buffer_select] = 1'b1;
		end
	end

	for (genvar g = 0; g < 2; g++) begin : g_frame
		tbb_ram #(.WIDTH(8), .DEPTH(FRAME_DEPTH)) u_ram (
			.clk(clk),
			.we(we[g]),
			.waddr(waddr),
			.wdata(wdata),
			.raddr(raddr[g]),
			.rdata(rdata[g])
		);
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			sel_q <= head.cmd.buffer_select;
		end
		if (st_q == ST_RUN) begin
			if (tap_q == 4'd1) begin
				sum_q <= {4'd0, src_data};
			end else if (tap_q >= 4'd2 && tap_q <= TAP_SUM) begin
				sum_q <= sum_q + {4'd0, src_data};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			pass_q <= 4'd0;
			npass_q <= 4'd0;
			pix_q <= '0;
			tap_q <= 4'd0;
			rsp_valid_q <= 1'b0;
			rsp_q <= 8'd0;
		end else begin
			if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (pop) begin
						if (head.cmd.opcode == OP_READ) begin
							st_q <= ST_READ;
						end else if (head.cmd.opcode == OP_RUN && pass_count != 4'd0) begin
							st_q <= ST_RUN;
							npass_q <= pass_count;
							pass_q <= 4'd0;
							pix_q <= '0;
							tap_q <= 4'd0;
						end else begin
							rsp_valid_q <= 1'b1;
							rsp_q <= 8'd0;
						end
					end
				end
				ST_READ: begin
					rsp_valid_q <= 1'b1;
					rsp_q <= rdata[sel_q];
					st_q <= ST_IDLE;
				end
				ST_RUN: begin
					if (tap_q == TAP_WRITE) begin
						tap_q <= 4'd0;
						pix_q <= pix_q + 1'b1;
						if (pix_q == '1) begin
							if (pass_q == npass_q - 4'd1) begin
								st_q <= ST_DONE;
							end else begin
								pass_q <= pass_q + 4'd1;
							end
						end
					end else begin
						tap_q <= tap_q + 4'd1;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						rsp_valid_q <= 1'b1;
						rsp_q <= 8'd0;
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data = rsp_q;

endmodule

### hdl/toroidal_box_blur_passes.sv
// ----------------------------------------------------------------------------
// toroidal_box_blur_passes
// Two height-map frames with sample access and toroidal 3x3 mean blur runs.
// ----------------------------------------------------------------------------
// Requests enter at one per cycle through a two-entry queue while it has
// room. A write or an unused opcode leaves the queue at one per cycle while
// the response channel is free and answers at once; a read holds the
// execution unit in its read state to capture the registered frame data.
// One response per request, in order. A run holds the execution unit for
// pass_count passes over every sample: each output sample takes nine reads
// through the single read port of the source frame, a step to close the sum
// and one to scale and write it. No pass clears the frames after reset.
`timescale 1ns / 1ps

module toroidal_box_blur_passes import tbb_pkg::*; (
	input logic clk,
	input logic arst_n,
	tbb_req_if.sink req,
	tbb_rsp_if.source rsp,
	input logic cfg_we,
	input logic [3:0] cfg_wdata
);

	// Ping-pong passes/run; user writes only while block is idle; unenforced
	logic [3:0] pass_count_q;
	q_head_t head;
	logic pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_count_q <= PASS_COUNT_RESET;
		end else if (cfg_we) begin
			pass_count_q <= cfg_wdata;
		end
	end

	// Intake: hold requests until the execution unit is free
	tbb_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.head(head),
		.pop(pop)
	);

	// Execution: frames, read data return and the blur sequencer
	tbb_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.pop(pop),
		.pass_count(pass_count_q),
		.rsp_valid(rsp.valid),
		.rsp_ready(rsp.ready),
		.rsp_data(rsp.read_value)
	);

endmodule

### hdl/tbb_checker.sv
// ----------------------------------------------------------------------------
// tbb_checker
// Port-level checks of the box blur block, bound to its top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "toroidal_box_blur_passes_assert.svh"

module tbb_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input logic [7:0] read_value
);

	logic [2:0] outstanding_q;
	logic req_acc;
	logic rsp_acc;

	assign req_acc = req_valid && req_ready;
	assign rsp_acc = rsp_valid && rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding_q <= 3'd0;
		end else begin
			outstanding_q <= outstanding_q + {2'd0, req_acc} - {2'd0, rsp_acc};
		end
	end

	`TBB_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
	`TBB_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(read_value))
	`TBB_ASSERT_NOW(a_no_spurious, rsp_valid, outstanding_q != 3'd0)
	`TBB_ASSERT_NOW(a_bounded, 1'b1, outstanding_q <= 3'd4)

endmodule

bind toroidal_box_blur_passes tbb_checker u_tbb_checker (
	.clk(clk),
	.arst_n(arst_n),
	.req_valid(req.valid),
	.req_ready(req.ready),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.read_value(rsp.read_value)
);
